// ===== sv/tjb_pkg.sv =====
package tjb_pkg;

    typedef struct packed {
        logic        cmd;
        logic [47:0] time_us;
        logic [15:0] packet_handle;
        logic [15:0] packet_len;
    } tjb_req_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] out_handle;
        logic [9:0]  out_len;
        logic [23:0] jitter_avg_us;
        logic        last;
    } tjb_res_t;

    // One ring entry as it sits in the slot memory.
    typedef struct packed {
        logic [15:0] handle;
        logic [9:0]  len;
        logic [47:0] time_us;
    } tjb_slot_t;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_DEPTH    = 2'd1,
        REG_INTERVAL = 2'd2,
        REG_HOLD     = 2'd3
    } tjb_reg_idx_t;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] MAX_PACKET_BYTES = 16'd512;
    localparam logic [15:0] KEEP_Q16         = 16'd62259;
    localparam logic [11:0] ALPHA_Q16        = 12'd3277;
    localparam logic [19:0] INTERVAL_RESET   = 20'd10000;
    localparam logic [47:0] DEV_MAX          = 48'hFF_FFFF;

    function automatic logic [9:0] clamp_len(input logic [15:0] len);
        logic [15:0] c;
        c = (len < MAX_PACKET_BYTES) ? len : MAX_PACKET_BYTES;
        return c[9:0];
    endfunction

endpackage

// ===== sv/timed_jitter_buffer_top.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_valid/req_ready    tjb_req_t: cmd, time_us, packet_handle, packet_len
// res       out  res_valid/res_ready    tjb_res_t: kind, out_handle, out_len, jitter_avg_us, last
// cfg       in   cfg_we                 cfg_idx (register index), cfg_wdata
//
// One request is worked on at a time. An arrival with a jitter update passes the gap,
// deviation, two multiply and sum steps and is queued in the dispatch step after them.
// Each released packet then passes the read and age check of the slot memory; the walk
// ends on an empty ring or when the oldest packet is still held, and the status result
// follows. Reset clears the ring pointers, fill count, jitter estimate and registers;
// slot memory is not cleared. A stalled res channel holds the sequencer at its next
// result; a new request is taken while the last status result still waits in the output
// register.
module timed_jitter_buffer_top
    import tjb_pkg::*;
#(
    parameter int RING_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  tjb_req_t    req,
    output logic        res_valid,
    input  logic        res_ready,
    output tjb_res_t    res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [23:0] cfg_wdata
);

    localparam int PTR_W = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W = $clog2(RING_SLOTS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_SLOTS);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_GAP  = 11'b000_0000_0010,
        S_DEV  = 11'b000_0000_0100,
        S_MULK = 11'b000_0000_1000,
        S_MULA = 11'b000_0001_0000,
        S_SUM  = 11'b000_0010_0000,
        S_DISP = 11'b000_0100_0000,
        S_PASS = 11'b000_1000_0000,
        S_RREQ = 11'b001_0000_0000,
        S_RCHK = 11'b010_0000_0000,
        S_STAT = 11'b100_0000_0000
    } tjb_state_t;

    tjb_state_t state_reg, state_next;

    logic        enable_reg, enable_next;
    logic [3:0]  depth_reg, depth_next;
    logic [19:0] interval_reg, interval_next;
    logic [23:0] hold_reg, hold_next;

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [47:0]      prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;
    logic [31:0]      jitter_reg, jitter_next;

    tjb_req_t    req_reg, req_next;
    logic [47:0] gap_reg, gap_next;
    logic [23:0] dev_reg, dev_next;
    logic [47:0] keep_prod_reg, keep_prod_next;
    logic [43:0] alpha_prod_reg, alpha_prod_next;

    logic     res_valid_reg, res_valid_next;
    tjb_res_t res_reg, res_next;

    tjb_slot_t slot_mem [RING_SLOTS];
    tjb_slot_t rd_data_reg;
    tjb_slot_t mem_wdata;
    logic      mem_we;
    logic      mem_re;

    logic        out_free;
    logic [47:0] diff;
    logic [47:0] age;
    logic [48:0] sum;
    logic        release_now;

    assign out_free  = !res_valid_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign diff = (gap_reg >= {28'd0, interval_reg}) ? gap_reg - {28'd0, interval_reg}
                                                     : {28'd0, interval_reg} - gap_reg;
    assign sum  = {1'b0, keep_prod_reg} + {5'd0, alpha_prod_reg};
    assign age  = req_reg.time_us - rd_data_reg.time_us;
    assign release_now = (req_reg.cmd == CMD_FLUSH) || (age >= {24'd0, hold_reg})
                         || (fill_reg == CNT_FULL);

    assign mem_wdata = '{handle:  req_reg.packet_handle,
                         len:     clamp_len(req_reg.packet_len),
                         time_us: req_reg.time_us};

    always_comb
    begin
        state_next      = state_reg;
        enable_next     = enable_reg;
        depth_next      = depth_reg;
        interval_next   = interval_reg;
        hold_next       = hold_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        fill_next       = fill_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        jitter_next     = jitter_reg;
        req_next        = req_reg;
        gap_next        = gap_reg;
        dev_next        = dev_reg;
        keep_prod_next  = keep_prod_reg;
        alpha_prod_next = alpha_prod_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ENABLE:   enable_next   = cfg_wdata[0];
                REG_DEPTH:    depth_next    = cfg_wdata[3:0];
                REG_INTERVAL: interval_next = cfg_wdata[19:0];
                REG_HOLD:     hold_next     = cfg_wdata;
                default:      ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    if (req.cmd == CMD_FLUSH)
                        state_next = enable_reg ? S_RREQ : S_STAT;
                    else if (enable_reg && (req.packet_len != 16'd0))
                        state_next = have_prev_reg ? S_GAP : S_DISP;
                    else
                        state_next = S_STAT;
                end
            end
            S_GAP:
            begin
                gap_next   = req_reg.time_us - prev_reg;
                state_next = S_DEV;
            end
            S_DEV:
            begin
                dev_next   = (diff > DEV_MAX) ? DEV_MAX[23:0] : diff[23:0];
                state_next = S_MULK;
            end
            S_MULK:
            begin
                keep_prod_next = 48'(jitter_reg) * 48'(KEEP_Q16);
                state_next     = S_MULA;
            end
            S_MULA:
            begin
                alpha_prod_next = 44'({dev_reg, 8'd0}) * 44'(ALPHA_Q16);
                state_next      = S_SUM;
            end
            S_SUM:
            begin
                jitter_next = sum[47:16];
                state_next  = S_DISP;
            end
            S_DISP:
            begin
                prev_next      = req_reg.time_us;
                have_prev_next = 1'b1;
                if (depth_reg == 4'd0)
                    state_next = S_PASS;
                else
                begin
                    // A full ring loses its oldest entry, so the count stays put.
                    if (fill_reg == CNT_FULL)
                        rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
                    else
                        fill_next = fill_reg + 1'b1;
                    mem_we     = 1'b1;
                    wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                    state_next = S_RREQ;
                end
            end
            S_PASS:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{kind: KIND_PACKET, out_handle: req_reg.packet_handle,
                                 out_len: clamp_len(req_reg.packet_len),
                                 jitter_avg_us: jitter_reg[31:8], last: 1'b0};
                    state_next = S_STAT;
                end
            end
            S_RREQ:
            begin
                if (fill_reg == '0)
                    state_next = S_STAT;
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (!release_now)
                    state_next = S_STAT;
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{kind: KIND_PACKET, out_handle: rd_data_reg.handle,
                                 out_len: rd_data_reg.len,
                                 jitter_avg_us: jitter_reg[31:8], last: 1'b0};
                    rptr_next  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_RREQ;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{kind: KIND_STATUS, out_handle: 16'd0, out_len: 10'd0,
                                 jitter_avg_us: jitter_reg[31:8], last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            depth_reg     <= 4'd0;
            interval_reg  <= INTERVAL_RESET;
            hold_reg      <= 24'd0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            prev_reg      <= 48'd0;
            have_prev_reg <= 1'b0;
            jitter_reg    <= 32'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            depth_reg     <= depth_next;
            interval_reg  <= interval_next;
            hold_reg      <= hold_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            fill_reg      <= fill_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            jitter_reg    <= jitter_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        gap_reg        <= gap_next;
        dev_reg        <= dev_next;
        keep_prod_reg  <= keep_prod_next;
        alpha_prod_reg <= alpha_prod_next;
        res_reg        <= res_next;
    end

    // Slot memory. The write happens in the dispatch step and the first read is
    // issued in the cycle after it, so a read never meets a write to the same slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[wptr_reg] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= slot_mem[rptr_reg];
    end

    // Write pointer expected from the read pointer and the fill count.
    logic [CNT_W:0] ptr_sum;
    logic [CNT_W:0] ptr_wrap;

    assign ptr_sum  = {1'b0, fill_reg} + (CNT_W + 1)'(rptr_reg);
    assign ptr_wrap = (ptr_sum >= (CNT_W + 1)'(RING_SLOTS))
                      ? ptr_sum - (CNT_W + 1)'(RING_SLOTS) : ptr_sum;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("ring fill count exceeds the number of slots");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_wrap[PTR_W-1:0] == wptr_reg)
        else $error("ring pointers disagree with the fill count");

    a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RCHK) |-> (fill_reg != '0))
        else $error("age check on an empty ring");

    a_jitter_update: assert property (@(posedge clk) disable iff (!rst_n)
        (jitter_reg != $past(jitter_reg)) |-> ($past(state_reg) == S_SUM))
        else $error("jitter estimate changed outside the sum step");

endmodule

// ===== dv/jitter_buffer_checker.sv =====
module jitter_buffer_checker
    import tjb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  tjb_req_t    req,
    input  logic        res_valid,
    input  logic        res_ready,
    input  tjb_res_t    res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [23:0] cfg_wdata,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              SLOTS       = 8;
    localparam logic [9:0]      LEN_CAP     = 10'd512;
    localparam longint unsigned EMA_KEEP    = 62259;
    localparam longint unsigned EMA_GAIN    = 3277;
    localparam logic [47:0]     DEV_CEILING = 48'hFF_FFFF;

    logic        enabled;
    logic [3:0]  depth;
    logic [19:0] interval_us;
    logic [23:0] hold_us;

    logic [15:0] slot_handle [SLOTS];
    logic [9:0]  slot_len    [SLOTS];
    logic [47:0] slot_stamp  [SLOTS];
    int          wr_slot;
    int          rd_slot;
    int          fill;
    logic [47:0] prev_stamp;
    logic        have_prev;
    logic [31:0] ema;

    tjb_res_t    expected_results [$];

    function automatic void queue_result(logic kind, logic [15:0] handle, logic [9:0] len,
                                         logic last);
        tjb_res_t r;
        r.kind          = kind;
        r.out_handle    = handle;
        r.out_len       = len;
        r.jitter_avg_us = ema[31:8];
        r.last          = last;
        expected_results.push_back(r);
    endfunction

    function automatic void release_oldest();
        queue_result(KIND_PACKET, slot_handle[rd_slot], slot_len[rd_slot], 1'b0);
        rd_slot = (rd_slot + 1) % SLOTS;
        fill--;
    endfunction

    function automatic logic [9:0] capped_len(logic [15:0] len);
        return (len < 16'(LEN_CAP)) ? len[9:0] : LEN_CAP;
    endfunction

    function automatic void predict_request(tjb_req_t r);
        logic [47:0] gap;
        logic [47:0] dev;
        logic [47:0] age;
        logic [63:0] acc;
        if (r.cmd == CMD_FLUSH)
        begin
            if (enabled)
            begin
                while (fill > 0)
                    release_oldest();
            end
        end
        else if (enabled && r.packet_len != 16'd0)
        begin
            if (have_prev)
            begin
                gap = r.time_us - prev_stamp;
                dev = (gap >= 48'(interval_us)) ? gap - 48'(interval_us)
                                                : 48'(interval_us) - gap;
                if (dev > DEV_CEILING)
                    dev = DEV_CEILING;
                acc = 64'(ema) * EMA_KEEP + (64'(dev) << 8) * EMA_GAIN;
                ema = acc[47:16];
            end
            prev_stamp = r.time_us;
            have_prev  = 1'b1;

            if (depth == 4'd0)
                queue_result(KIND_PACKET, r.packet_handle, capped_len(r.packet_len), 1'b0);
            else
            begin
                // A full ring loses its oldest packet silently.
                if (fill >= SLOTS)
                begin
                    rd_slot = (rd_slot + 1) % SLOTS;
                    fill--;
                end
                slot_handle[wr_slot] = r.packet_handle;
                slot_len[wr_slot]    = capped_len(r.packet_len);
                slot_stamp[wr_slot]  = r.time_us;
                wr_slot = (wr_slot + 1) % SLOTS;
                fill++;

                // Ages wrap at 48 bits, so a step back in time releases the packet.
                while (fill > 0)
                begin
                    age = r.time_us - slot_stamp[rd_slot];
                    if (age >= 48'(hold_us) || fill > SLOTS - 1)
                        release_oldest();
                    else
                        break;
                end
            end
        end
        queue_result(KIND_STATUS, 16'd0, 10'd0, 1'b1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tjb_res_t want;
        if (!rst_n)
        begin
            enabled     = 1'b0;
            depth       = 4'd0;
            interval_us = 20'd10000;
            hold_us     = 24'd0;
            wr_slot     = 0;
            rd_slot     = 0;
            fill        = 0;
            prev_stamp  = '0;
            have_prev   = 1'b0;
            ema         = '0;
            expected_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"unexpected result: kind=%0d handle=%h len=%0d ",
                                  "jitter=%0d last=%0d"},
                                 res.kind, res.out_handle, res.out_len, res.jitter_avg_us,
                                 res.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.kind !== want.kind || res.out_handle !== want.out_handle ||
                        res.out_len !== want.out_len ||
                        res.jitter_avg_us !== want.jitter_avg_us || res.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected kind=%0d handle=%h len=%0d ",
                                      "jitter=%0d last=%0d, got kind=%0d handle=%h len=%0d ",
                                      "jitter=%0d last=%0d"},
                                     want.kind, want.out_handle, want.out_len,
                                     want.jitter_avg_us, want.last, res.kind, res.out_handle,
                                     res.out_len, res.jitter_avg_us, res.last);
                    end
                end
            end

            if (cfg_we)
            begin
                unique case (tjb_reg_idx_t'(cfg_idx))
                    REG_ENABLE:   enabled     = cfg_wdata[0];
                    REG_DEPTH:    depth       = cfg_wdata[3:0];
                    REG_INTERVAL: interval_us = cfg_wdata[19:0];
                    REG_HOLD:     hold_us     = cfg_wdata;
                    default:      ;
                endcase
            end

            if (req_valid && req_ready)
                predict_request(req);

            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/timed_jitter_buffer_top_test.sv =====
module timed_jitter_buffer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tjb_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 35;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    tjb_req_t    req       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    tjb_res_t    res;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = '0;
    logic [23:0] cfg_wdata = '0;

    int          fail_count;
    int          outstanding;
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          quiet_cycles = 0;
    logic [47:0] now_us       = '0;
    logic [19:0] cur_interval = 20'd10000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    timed_jitter_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    jitter_buffer_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic tjb_req_t arrival(logic [47:0] t, logic [15:0] handle, logic [15:0] len);
        tjb_req_t r;
        r.cmd           = CMD_ARRIVAL;
        r.time_us       = t;
        r.packet_handle = handle;
        r.packet_len    = len;
        return r;
    endfunction

    // Flush requests carry junk in the fields the block ignores.
    function automatic tjb_req_t flush_req();
        tjb_req_t r;
        r.cmd           = CMD_FLUSH;
        r.time_us       = 48'({$urandom, $urandom});
        r.packet_handle = 16'($urandom);
        r.packet_len    = 16'($urandom);
        return r;
    endfunction

    task automatic write_reg(tjb_reg_idx_t idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic apply_config(logic en, logic [3:0] depth, logic [19:0] interval,
                                logic [23:0] hold);
        wait_drained();
        write_reg(REG_ENABLE, 24'(en));
        write_reg(REG_DEPTH, 24'(depth));
        write_reg(REG_INTERVAL, 24'(interval));
        write_reg(REG_HOLD, hold);
        cur_interval = interval;
    endtask

    task automatic send_request(tjb_req_t r);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // Mostly on-schedule arrivals with jitter around the interval, plus the odd
    // flush, empty packet, full-range length, jump to an arbitrary time and step backwards.
    task automatic send_random_item();
        int       pick;
        longint   spread;
        longint   delta;
        tjb_req_t r;
        pick   = $urandom_range(99);
        spread = (cur_interval == 20'd0) ? 64 : longint'(cur_interval);
        delta  = longint'(cur_interval) + longint'($urandom_range(0, spread)) - spread / 2;
        if (pick < 4)
            now_us = 48'({$urandom, $urandom});
        else if (pick < 8)
            now_us = now_us - 48'($urandom_range(1, 3 * spread));
        else
            now_us = now_us + 48'(delta);

        if (pick >= 92)
            r = flush_req();
        else if (pick >= 87)
            r = arrival(now_us, 16'($urandom), 16'd0);
        else if (pick >= 75)
            r = arrival(now_us, 16'($urandom), 16'($urandom));
        else
            r = arrival(now_us, 16'($urandom), 16'($urandom_range(1, 600)));
        send_request(r);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Still disabled after reset: status only, for an arrival and a flush.
        send_request(arrival(48'd100, 16'd1, 16'd100));
        send_request(flush_req());

        // Passthrough with length clamping and wrapping time gaps.
        apply_config(1'b1, 4'd0, 20'd10000, 24'd0);
        send_request(arrival(48'd50, 16'd7, 16'd0));
        send_request(arrival(48'd0, 16'h0000, 16'd1));
        send_request(arrival(48'd10000, 16'hFFFF, 16'd512));
        send_request(arrival(48'd25000, 16'h1234, 16'd513));
        send_request(arrival(48'hFFFF_FFFF_FFFF, 16'hA5A5, 16'hFFFF));
        send_request(arrival(48'd5, 16'h5A5A, 16'h8000));

        // Buffered with a short hold, then a step back in time and a flush.
        apply_config(1'b1, 4'd3, 20'd1000, 24'd2000);
        send_request(arrival(48'd1000, 16'h0101, 16'd64));
        send_request(arrival(48'd2000, 16'h0202, 16'd65));
        send_request(arrival(48'd3000, 16'h0303, 16'd66));
        send_request(arrival(48'd4000, 16'h0404, 16'd67));
        send_request(arrival(48'd500, 16'h0505, 16'd68));
        send_request(flush_req());

        // Maximum hold: the ring fills and overflow forces releases.
        apply_config(1'b1, 4'd8, 20'd1000, 24'hFF_FFFF);
        for (int i = 0; i < 9; i++)
            send_request(arrival(48'(6000 + 1000 * i), 16'(16'h1000 + i), 16'(100 + i)));

        // Depth dropped to zero with packets still queued, then a full flush.
        apply_config(1'b1, 4'd0, 20'd1000, 24'hFF_FFFF);
        send_request(arrival(48'd20000, 16'hBEEF, 16'd200));
        send_request(flush_req());
        now_us = 48'd20000;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            logic [3:0]      depth;
            logic [19:0]     interval;
            logic [23:0]     hold;
            longint unsigned span;
            depth = (phase == 2 || phase == 7) ? 4'd0 :
                    (phase == 9) ? 4'd15 : 4'($urandom_range(1, 15));
            case (phase)
                3:       interval = 20'd0;
                4:       interval = 20'd1000000;
                5:       interval = 20'hFFFFF;
                8:       interval = 20'd1;
                default: interval = 20'($urandom_range(200, 20000));
            endcase
            span = longint'(depth) * interval;
            case (phase)
                1:       hold = 24'd0;
                9:       hold = 24'hFF_FFFF;
                default: hold = (span > 64'hFF_FFFF) ? 24'hFF_FFFF : span[23:0];
            endcase
            apply_config(phase != 6, depth, interval, hold);

            case (phase % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 48;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 48;
                end
                default:
                begin
                    send_gap_pct = 28;
                    stall_pct    = 28;
                end
            endcase

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_item();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
